/* rtl/core/dcc_fge_pkg.sv */
// Package for the DCC function-group encoder: item codes, controller states,
// command/status structs between controller and datapath. No dependencies.
package dcc_fge_pkg;

	localparam int FLAG_W = 29;          // F0..F28
	localparam int FNUM_MAX = 28;        // highest function number

	// Instruction byte bases of the five function groups
	localparam logic [7:0] GRP1_BASE = 8'd128;
	localparam logic [7:0] GRP2_BASE = 8'd176;
	localparam logic [7:0] GRP3_BASE = 8'd160;
	localparam logic [7:0] GRP4_BYTE = 8'd222;
	localparam logic [7:0] GRP5_BYTE = 8'd223;

	typedef logic [FLAG_W-1:0] flags_t;
	typedef logic [1:0]        func_t;
	typedef logic [3:0]        slot_t;
	typedef logic [13:0]       addr_t;
	typedef logic [4:0]        fnum_t;
	typedef logic [7:0]        byte_t;

	// Item operation codes
	localparam func_t FN_ON    = 2'd0;
	localparam func_t FN_OFF   = 2'd1;
	localparam func_t FN_EMIT  = 2'd2;
	localparam func_t FN_CLEAR = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_WORK
	} ctrl_state_t;

	// Controller -> datapath
	typedef struct packed {
		logic load;     // capture the incoming transaction
		logic commit;   // apply the held item to the flags and output
	} dp_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic is_emit;  // held item produces a result
		logic out_busy; // output register full and not taken this cycle
	} dp_sts_t;

endpackage

/* rtl/core/dcc_fge_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on dcc_fge_pkg for the payload types.
interface dcc_fge_in_if;
	import dcc_fge_pkg::*;
	logic  valid;
	logic  ready;
	func_t func;
	logic  track;
	slot_t slot;
	addr_t loco_address;
	fnum_t function_number;

	modport source (output valid, func, track, slot, loco_address, function_number,
		input ready);
	modport sink (input valid, func, track, slot, loco_address, function_number,
		output ready);
endinterface

interface dcc_fge_out_if;
	import dcc_fge_pkg::*;
	logic  valid;
	logic  ready;
	logic  out_track;
	slot_t out_slot;
	addr_t out_address;
	byte_t first_byte;
	byte_t second_byte;
	logic  second_valid;
	logic  any_changed;

	modport source (output valid, out_track, out_slot, out_address, first_byte,
		second_byte, second_valid, any_changed, input ready);
	modport sink (input valid, out_track, out_slot, out_address, first_byte,
		second_byte, second_valid, any_changed, output ready);
endinterface

/* rtl/core/dcc_function_group_encoder_top.sv */
// DCC function-group encoder. Each item is handled by a capture of the
// transaction followed by the read-modify-write of the slot's flag words;
// a new item is accepted only after the previous one is committed. An emit
// stays in its work state while the output register still holds a result
// that has not been taken; on/off/clear items never wait on the output side.
// Flag storage covers min(SLOT_COUNT, 16) slots and is cleared by reset at once.
module dcc_function_group_encoder_top #(
	parameter int SLOT_COUNT = 16
) (
	input logic           clk,
	input logic           arst_n,
	dcc_fge_in_if.sink    req,
	dcc_fge_out_if.source rsp
);
	import dcc_fge_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	dcc_fge_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (req.ready)
	);

	dcc_fge_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.func            (req.func),
		.track           (req.track),
		.slot            (req.slot),
		.loco_address    (req.loco_address),
		.function_number (req.function_number),
		.out_ready       (rsp.ready),
		.out_valid       (rsp.valid),
		.out_track       (rsp.out_track),
		.out_slot        (rsp.out_slot),
		.out_address     (rsp.out_address),
		.first_byte      (rsp.first_byte),
		.second_byte     (rsp.second_byte),
		.second_valid    (rsp.second_valid),
		.any_changed     (rsp.any_changed)
	);

`ifndef SYNTHESIS
	// One item in flight: no transaction directly after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("input accepted while an item is in flight");

	// A clear item never produces a result
	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.func == FN_CLEAR && !rsp.valid |=> ##1 !rsp.valid)
		else $error("result produced by a clear item");

	// Nothing changed means an empty instruction
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.any_changed || (rsp.first_byte == '0 && !rsp.second_valid)))
		else $error("instruction bytes without any changed group");
`endif

endmodule

/* rtl/core/dcc_fge_ctrl.sv */
// Controller of the function-group encoder: sequences capture and commit.
// Depends on dcc_fge_pkg.
module dcc_fge_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  dcc_fge_pkg::dp_sts_t sts,
	output dcc_fge_pkg::dp_cmd_t cmd,
	output logic                in_ready
);
	import dcc_fge_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        work_done;

	// An emit waits while the previous result is still unclaimed
	assign work_done = !(sts.is_emit && sts.out_busy);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_WORK;
			end
			ST_WORK: begin
				if (work_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_WORK: begin
				cmd.commit = work_done;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/dcc_fge_dp.sv */
// Datapath of the function-group encoder: item register, per-slot flag
// storage, group selection and result register. Depends on dcc_fge_pkg.
module dcc_fge_dp #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dcc_fge_pkg::dp_cmd_t cmd,
	output dcc_fge_pkg::dp_sts_t sts,
	input  dcc_fge_pkg::func_t   func,
	input  logic                 track,
	input  dcc_fge_pkg::slot_t   slot,
	input  dcc_fge_pkg::addr_t   loco_address,
	input  dcc_fge_pkg::fnum_t   function_number,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic                 out_track,
	output dcc_fge_pkg::slot_t   out_slot,
	output dcc_fge_pkg::addr_t   out_address,
	output dcc_fge_pkg::byte_t   first_byte,
	output dcc_fge_pkg::byte_t   second_byte,
	output logic                 second_valid,
	output logic                 any_changed
);
	import dcc_fge_pkg::*;

	// Only 16 slots are addressable by the slot field
	localparam int DEPTH = (SLOT_COUNT < 16) ? SLOT_COUNT : 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Held item
	func_t func_q;
	logic  track_q;
	slot_t slot_q;
	addr_t addr_q;
	fnum_t fnum_q;

	flags_t on_q   [DEPTH];
	flags_t sent_q [DEPTH];

	logic             slot_ok;
	logic [IDX_W-1:0] idx;
	flags_t           on_cur, sent_cur, diff, fmask;
	logic             fnum_ok;
	byte_t            b1, b2;
	logic             b2v;
	logic             out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			track_q <= track;
			slot_q  <= slot;
			addr_q  <= loco_address;
			fnum_q  <= function_number;
		end
	end

	// Slot lookup; out-of-range slots read as all-zero flags
	assign slot_ok  = (9'(slot_q) < 9'(SLOT_COUNT));
	assign idx      = slot_ok ? slot_q[IDX_W-1:0] : '0;
	assign on_cur   = slot_ok ? on_q[idx] : '0;
	assign sent_cur = slot_ok ? sent_q[idx] : '0;
	assign diff     = on_cur ^ sent_cur;
	assign fnum_ok  = (fnum_q <= fnum_t'(FNUM_MAX));
	assign fmask    = flags_t'(1) << fnum_q;

	// Highest-numbered changed group wins
	always_comb begin
		b1  = '0;
		b2  = '0;
		b2v = 1'b0;
		priority if (diff[28:21] != '0) begin
			b1  = GRP5_BYTE;
			b2  = on_cur[28:21];
			b2v = 1'b1;
		end else if (diff[20:13] != '0) begin
			b1  = GRP4_BYTE;
			b2  = on_cur[20:13];
			b2v = 1'b1;
		end else if (diff[12:9] != '0) begin
			b1 = GRP3_BASE | {4'd0, on_cur[12:9]};
		end else if (diff[8:5] != '0) begin
			b1 = GRP2_BASE | {4'd0, on_cur[8:5]};
		end else if (diff[4:0] != '0) begin
			b1 = GRP1_BASE | {3'd0, on_cur[0], on_cur[4:1]};
		end else begin
			// no group changed: empty instruction
			b1 = '0;
		end
	end

	// Flag update on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				on_q[i]   <= '0;
				sent_q[i] <= '0;
			end
		end else if (cmd.commit && slot_ok) begin
			unique case (func_q)
				FN_ON: begin
					if (fnum_ok) on_q[idx] <= on_cur | fmask;
				end
				FN_OFF: begin
					if (fnum_ok) on_q[idx] <= on_cur & ~fmask;
				end
				FN_EMIT: begin
					sent_q[idx] <= on_cur;
				end
				FN_CLEAR: begin
					on_q[idx]   <= '0;
					sent_q[idx] <= '0;
				end
				default: ;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit && func_q == FN_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && func_q == FN_EMIT) begin
			out_track    <= track_q;
			out_slot     <= slot_q;
			out_address  <= addr_q;
			first_byte   <= b1;
			second_byte  <= b2;
			second_valid <= b2v;
			any_changed  <= (diff != '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.is_emit  = (func_q == FN_EMIT);
	assign sts.out_busy = out_valid_q && !out_ready;

endmodule

/* sim/dcc_fge_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the DCC function-group encoder: watches both channels,
// keeps its own per-slot flag state and checks each result in order.
// Depends on dcc_fge_pkg and the channel interfaces in dcc_fge_if.
module dcc_fge_checker #(
	parameter int SLOT_COUNT = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	dcc_fge_in_if  req,
	dcc_fge_out_if rsp,
	output int     mismatches,
	output int     checked,
	output int     pending
);
	import dcc_fge_pkg::*;

	typedef struct packed {
		logic  trk;
		slot_t slot;
		addr_t addr;
		byte_t b1;
		byte_t b2;
		logic  b2v;
		logic  chg;
	} fg_instr_t;

	flags_t    func_flags [16];
	flags_t    sent_flags [16];
	fg_instr_t instr_q [$];
	int        fails;
	int        n_checked;

	// Pick the highest changed group and build its instruction bytes
	function automatic fg_instr_t encode_group(flags_t on, flags_t diff);
		fg_instr_t r;
		r = '0;
		if (diff[4:0] != '0)
			r.b1 = GRP1_BASE + {3'b000, on[0], on[4:1]};
		if (diff[8:5] != '0)
			r.b1 = GRP2_BASE + {4'b0000, on[8:5]};
		if (diff[12:9] != '0)
			r.b1 = GRP3_BASE + {4'b0000, on[12:9]};
		if (diff[20:13] != '0) begin
			r.b1  = GRP4_BYTE;
			r.b2  = on[20:13];
			r.b2v = 1'b1;
		end
		if (diff[28:21] != '0) begin
			r.b1  = GRP5_BYTE;
			r.b2  = on[28:21];
			r.b2v = 1'b1;
		end
		r.chg = (diff != '0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track_and_check
		fg_instr_t want;
		flags_t    on_w;
		flags_t    diff_w;
		logic      slot_ok;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				func_flags[i] = '0;
				sent_flags[i] = '0;
			end
			instr_q.delete();
			fails      = 0;
			n_checked  = 0;
			mismatches <= 0;
			checked    <= 0;
			pending    <= 0;
		end else begin
			// result side first: it can only belong to an earlier transaction
			if (rsp.valid && rsp.ready) begin
				if (instr_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: result with nothing expected (slot %0d, byte1 %0d)",
							$realtime, rsp.out_slot, rsp.first_byte);
				end else begin
					want = instr_q.pop_front();
					n_checked++;
					if (rsp.out_track !== want.trk || rsp.out_slot !== want.slot ||
							rsp.out_address !== want.addr || rsp.first_byte !== want.b1 ||
							rsp.second_byte !== want.b2 || rsp.second_valid !== want.b2v ||
							rsp.any_changed !== want.chg) begin
						fails++;
						if (fails <= 10) begin
							$display("%0t: mismatch exp trk=%0d slot=%0d addr=%0d b1=%0d b2=%0d v2=%0d chg=%0d",
								$realtime, want.trk, want.slot, want.addr, want.b1, want.b2,
								want.b2v, want.chg);
							$display("%0t:          got trk=%0d slot=%0d addr=%0d b1=%0d b2=%0d v2=%0d chg=%0d",
								$realtime, rsp.out_track, rsp.out_slot, rsp.out_address,
								rsp.first_byte, rsp.second_byte, rsp.second_valid,
								rsp.any_changed);
						end
					end
				end
			end

			// input side: update the flag state, queue the instruction on emit
			if (req.valid && req.ready) begin
				slot_ok = (int'(req.slot) < SLOT_COUNT);
				case (req.func)
					FN_ON, FN_OFF: begin
						if (slot_ok && req.function_number <= FNUM_MAX)
							func_flags[req.slot][req.function_number] = (req.func == FN_ON);
					end
					FN_CLEAR: begin
						if (slot_ok) begin
							func_flags[req.slot] = '0;
							sent_flags[req.slot] = '0;
						end
					end
					default: begin
						on_w   = slot_ok ? func_flags[req.slot] : '0;
						diff_w = slot_ok ? (on_w ^ sent_flags[req.slot]) : '0;
						want      = encode_group(on_w, diff_w);
						want.trk  = req.track;
						want.slot = req.slot;
						want.addr = req.loco_address;
						instr_q.push_back(want);
						if (slot_ok)
							sent_flags[req.slot] = on_w;
					end
				endcase
			end

			mismatches <= fails;
			checked    <= n_checked;
			pending    <= instr_q.size();
		end
	end

endmodule

/* sim/dcc_function_group_encoder_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the DCC function-group encoder: clock, reset, item
// stimulus with bursty sending and receiver stalls, and the verdict.
// Depends on dcc_fge_pkg, dcc_fge_if, the encoder RTL and dcc_fge_checker.
module dcc_function_group_encoder_top_tb;
	import dcc_fge_pkg::*;

	logic clk;
	logic arst_n;
	logic draining;
	int   mismatches;
	int   checked;
	int   pending;
	int   items_sent;
	int   burst_left;

	dcc_fge_in_if  req_ch ();
	dcc_fge_out_if rsp_ch ();

	dcc_function_group_encoder_top #(.SLOT_COUNT(16)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	dcc_fge_checker #(.SLOT_COUNT(16)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.checked    (checked),
		.pending    (pending)
	);

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Overall time limit
	initial begin
		#10ms;
		$display("simulation failed");
		$finish;
	end

	// Offer one transaction and hold it until accepted; bursts end in a random gap
	task automatic put(func_t f, logic trk, slot_t s, addr_t a, fnum_t n);
		int gap;
		req_ch.valid           <= 1'b1;
		req_ch.func            <= f;
		req_ch.track           <= trk;
		req_ch.slot            <= s;
		req_ch.loco_address    <= a;
		req_ch.function_number <= n;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		items_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Receiver pacing: changing stall modes plus one long hold-off
	initial begin : rx_pacing
		int unsigned cyc;
		int unsigned mode;
		rsp_ch.ready <= 1'b0;
		cyc  = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			if (draining)
				rsp_ch.ready <= 1'b1;
			else if (cyc >= 1200 && cyc < 1600)
				rsp_ch.ready <= 1'b0;
			else begin
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= cyc[2];
				endcase
			end
		end
	end

	// Stimulus and verdict
	initial begin : stimulus
		int    r;
		int    useful;
		func_t f;
		slot_t s;
		addr_t a;
		fnum_t n;
		draining   = 1'b0;
		items_sent = 0;
		burst_left = 1;
		arst_n                 <= 1'b0;
		req_ch.valid           <= 1'b0;
		req_ch.func            <= FN_ON;
		req_ch.track           <= 1'b0;
		req_ch.slot            <= '0;
		req_ch.loco_address    <= '0;
		req_ch.function_number <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: untouched slot, each group alone, several groups at once
		put(FN_EMIT, 1'b0, 4'd0, 14'd0, 5'd0);
		put(FN_ON,   1'b0, 4'd0, 14'd0, 5'd0);
		put(FN_ON,   1'b0, 4'd0, 14'd0, 5'd1);
		put(FN_ON,   1'b0, 4'd0, 14'd0, 5'd4);
		put(FN_EMIT, 1'b0, 4'd0, 14'd3, 5'd0);
		put(FN_ON,   1'b0, 4'd0, 14'd0, 5'd5);
		put(FN_ON,   1'b0, 4'd0, 14'd0, 5'd8);
		put(FN_EMIT, 1'b0, 4'd0, 14'd3, 5'd0);
		put(FN_ON,   1'b0, 4'd0, 14'd0, 5'd9);
		put(FN_ON,   1'b0, 4'd0, 14'd0, 5'd12);
		put(FN_EMIT, 1'b0, 4'd0, 14'd3, 5'd0);
		put(FN_ON,   1'b0, 4'd0, 14'd0, 5'd13);
		put(FN_ON,   1'b0, 4'd0, 14'd0, 5'd20);
		put(FN_EMIT, 1'b0, 4'd0, 14'd3, 5'd0);
		put(FN_ON,   1'b0, 4'd0, 14'd0, 5'd21);
		put(FN_ON,   1'b0, 4'd0, 14'd0, 5'd28);
		put(FN_EMIT, 1'b0, 4'd0, 14'd3, 5'd0);
		put(FN_OFF,  1'b0, 4'd0, 14'd0, 5'd0);
		put(FN_OFF,  1'b0, 4'd0, 14'd0, 5'd28);
		put(FN_EMIT, 1'b0, 4'd0, 14'd3, 5'd0);
		// function numbers past F28 are ignored, so nothing has changed
		put(FN_ON,   1'b0, 4'd0, 14'd0, 5'd29);
		put(FN_OFF,  1'b0, 4'd0, 14'd0, 5'd31);
		put(FN_EMIT, 1'b0, 4'd0, 14'd3, 5'd0);
		// clear wipes flags and sent copy alike
		put(FN_CLEAR, 1'b0, 4'd0, 14'd0, 5'd0);
		put(FN_EMIT,  1'b0, 4'd0, 14'd3, 5'd0);
		// top slot, programming track, address extremes
		put(FN_ON,   1'b1, 4'd15, 14'd10239, 5'd7);
		put(FN_EMIT, 1'b1, 4'd15, 14'h3FFF,  5'd30);

		// random: few hot slots so flags pile up between emits
		useful = 0;
		while (useful < 2000) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				f = FN_ON;
			else if (r < 60)
				f = FN_OFF;
			else if (r < 95)
				f = FN_EMIT;
			else
				f = FN_CLEAR;
			s = ($urandom_range(0, 3) == 0) ? slot_t'($urandom_range(0, 15))
				: slot_t'($urandom_range(0, 3));
			n = ($urandom_range(0, 15) == 0) ? fnum_t'($urandom_range(29, 31))
				: fnum_t'($urandom_range(0, 28));
			a = ($urandom_range(0, 7) == 0) ? addr_t'($urandom_range(10240, 16383))
				: addr_t'($urandom_range(0, 10239));
			put(f, 1'($urandom_range(0, 1)), s, a, n);
			if (!((f == FN_ON || f == FN_OFF) && n > FNUM_MAX))
				useful++;
		end
		req_ch.valid <= 1'b0;

		// drain outstanding results, then allow for a late stray one
		@(posedge clk);
		draining = 1'b1;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d transactions over 16 slots incl. a long output hold-off;",
			items_sent);
		$display("checked %0d function-group results, %0d mismatches", checked, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/dcc_fge_pkg.sv
rtl/core/dcc_fge_if.sv
rtl/core/dcc_fge_ctrl.sv
rtl/core/dcc_fge_dp.sv
rtl/core/dcc_function_group_encoder_top.sv
sim/dcc_fge_checker.sv
sim/dcc_function_group_encoder_top_tb.sv
